>>> design/i2c_register_access_master_top_assert.svh
// ----------------------------------------------------------------------------
// I2C register access master assertion macros
// Clocked property macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_ASSERT_SVH

// check a property outside reset
`define I2CRAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define I2CRAM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master package
// Request and response payload types and command codes.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_READ_BYTE = 2'd1;
    localparam logic [1:0] OP_READ_WORD = 2'd2;
    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] op;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } i2cram_req_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        ack_missing;
    } i2cram_rsp_t;

endpackage

>>> design/i2c_register_access_master_top.sv
// ----------------------------------------------------------------------------
// I2C register access master
// Half-bit tick sequencer for single-register write, byte read and word read.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | i2cram_req_t, one bus tick
//  rsp     | out       | rsp_valid / rsp_ready | i2cram_rsp_t, one per request
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data, 7-bit device address
//
// One request per cycle while req_ready is high; its response is registered and shows the cycle after.
// The sequencer advances one phase per request in a single pass of logic.
// req_ready drops only while a response waits and rsp_ready is low.
// rst_n clears the sequencer and the address; the bus idles released.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module i2c_register_access_master_top
    import i2cram_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  i2cram_req_t req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output i2cram_rsp_t rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    typedef enum logic [14:0] {
        PH_IDLE       = 15'b000_0000_0000_0001,
        PH_START      = 15'b000_0000_0000_0010,
        PH_START_HOLD = 15'b000_0000_0000_0100,
        PH_TX_LO      = 15'b000_0000_0000_1000,
        PH_TX_HI      = 15'b000_0000_0001_0000,
        PH_TACK_LO    = 15'b000_0000_0010_0000,
        PH_TACK_HI    = 15'b000_0000_0100_0000,
        PH_RX_LO      = 15'b000_0000_1000_0000,
        PH_RX_HI      = 15'b000_0001_0000_0000,
        PH_MACK_LO    = 15'b000_0010_0000_0000,
        PH_MACK_HI    = 15'b000_0100_0000_0000,
        PH_RS_LO      = 15'b000_1000_0000_0000,
        PH_RS_HI      = 15'b001_0000_0000_0000,
        PH_SP_LO      = 15'b010_0000_0000_0000,
        PH_SP_HI      = 15'b100_0000_0000_0000
    } phase_t;

    typedef enum logic [5:0] {
        ST_ADDR_W = 6'b00_0001,
        ST_REG    = 6'b00_0010,
        ST_DATA   = 6'b00_0100,
        ST_ADDR_R = 6'b00_1000,
        ST_READ1  = 6'b01_0000,
        ST_READ2  = 6'b10_0000
    } stage_t;

    phase_t      phase_reg, phase_next;
    stage_t      stage_reg, stage_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [1:0]  op_reg, op_next;
    logic [7:0]  reg_addr_reg, reg_addr_next;
    logic [7:0]  data_reg, data_next;
    logic [15:0] read_word_reg, read_word_next;
    logic        nack_reg, nack_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic [6:0]  dev_addr_reg;
    logic        done_next;
    logic        rsp_valid_reg;
    i2cram_rsp_t rsp_reg;
    logic        step;
    logic [7:0]  rx_byte;
    logic        more;

    function automatic logic [7:0] tx_byte(stage_t st, logic [6:0] dev, logic [7:0] ra,
                                           logic [7:0] wd);
        logic [7:0] v;
        unique case (st)
            ST_ADDR_W: v = {dev, 1'b0};
            ST_REG:    v = ra;
            ST_DATA:   v = wd;
            default:   v = {dev, 1'b1};
        endcase
        return v;
    endfunction

    assign step      = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rx_byte   = {shift_reg[6:0], req.sda_in};
    assign more      = (stage_reg == ST_READ1) && (op_reg == OP_READ_WORD);

    always_comb
    begin
        phase_next     = phase_reg;
        stage_next     = stage_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        op_next        = op_reg;
        reg_addr_next  = reg_addr_reg;
        data_next      = data_reg;
        read_word_next = read_word_reg;
        nack_next      = nack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        done_next      = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.cmd_valid && (req.op != OP_UNDEFINED))
                begin
                    op_next       = req.op;
                    reg_addr_next = req.reg_addr;
                    data_next     = req.write_data;
                    nack_next     = 1'b0;
                    stage_next    = ST_ADDR_W;
                    phase_next    = PH_START;
                    scl_next      = 1'b1;
                    sda_next      = 1'b0;
                end
                else
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
            end
            PH_START:
            begin
                phase_next = PH_START_HOLD;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
            end
            PH_START_HOLD:
            begin
                shift_next     = tx_byte(stage_reg, dev_addr_reg, reg_addr_reg, data_reg);
                bit_count_next = 3'd0;
                phase_next     = PH_TX_LO;
                scl_next       = 1'b0;
                sda_next       = shift_next[7];
            end
            PH_TX_LO:
            begin
                phase_next = PH_TX_HI;
                scl_next   = 1'b1;
            end
            PH_TX_HI:
            begin
                if (bit_count_reg == 3'd7)
                begin
                    phase_next = PH_TACK_LO;
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                end
                else
                begin
                    bit_count_next = bit_count_reg + 3'd1;
                    shift_next     = {shift_reg[6:0], 1'b0};
                    phase_next     = PH_TX_LO;
                    scl_next       = 1'b0;
                    sda_next       = shift_reg[6];
                end
            end
            PH_TACK_LO:
            begin
                phase_next = PH_TACK_HI;
                scl_next   = 1'b1;
                sda_next   = 1'b1;
            end
            PH_TACK_HI:
            begin
                if (req.sda_in)
                begin
                    nack_next = 1'b1;
                end
                scl_next = 1'b0;
                priority if (stage_reg == ST_ADDR_W)
                begin
                    stage_next     = ST_REG;
                    shift_next     = reg_addr_reg;
                    bit_count_next = 3'd0;
                    phase_next     = PH_TX_LO;
                    sda_next       = reg_addr_reg[7];
                end
                else if (stage_reg == ST_REG && op_reg == OP_WRITE)
                begin
                    stage_next     = ST_DATA;
                    shift_next     = data_reg;
                    bit_count_next = 3'd0;
                    phase_next     = PH_TX_LO;
                    sda_next       = data_reg[7];
                end
                else if (stage_reg == ST_REG)
                begin
                    stage_next = ST_ADDR_R;
                    phase_next = PH_RS_LO;
                    sda_next   = 1'b1;
                end
                else if (stage_reg == ST_ADDR_R)
                begin
                    stage_next     = ST_READ1;
                    shift_next     = 8'd0;
                    bit_count_next = 3'd0;
                    phase_next     = PH_RX_LO;
                    sda_next       = 1'b1;
                end
                else
                begin
                    phase_next = PH_SP_LO;
                    sda_next   = 1'b0;
                end
            end
            PH_RS_LO:
            begin
                phase_next = PH_RS_HI;
                scl_next   = 1'b1;
                sda_next   = 1'b1;
            end
            PH_RS_HI:
            begin
                phase_next = PH_START;
                scl_next   = 1'b1;
                sda_next   = 1'b0;
            end
            PH_RX_LO:
            begin
                phase_next = PH_RX_HI;
                scl_next   = 1'b1;
                sda_next   = 1'b1;
            end
            PH_RX_HI:
            begin
                shift_next = rx_byte;
                scl_next   = 1'b0;
                if (bit_count_reg == 3'd7)
                begin
                    priority if (more)
                    begin
                        read_word_next = {rx_byte, 8'd0};
                    end
                    else if (stage_reg == ST_READ1)
                    begin
                        read_word_next = {8'd0, rx_byte};
                    end
                    else
                    begin
                        read_word_next = {read_word_reg[15:8], rx_byte};
                    end
                    phase_next = PH_MACK_LO;
                    sda_next   = !more;
                end
                else
                begin
                    bit_count_next = bit_count_reg + 3'd1;
                    phase_next     = PH_RX_LO;
                    sda_next       = 1'b1;
                end
            end
            PH_MACK_LO:
            begin
                phase_next = PH_MACK_HI;
                scl_next   = 1'b1;
            end
            PH_MACK_HI:
            begin
                scl_next = 1'b0;
                if (!sda_reg && stage_reg == ST_READ1)
                begin
                    stage_next     = ST_READ2;
                    shift_next     = 8'd0;
                    bit_count_next = 3'd0;
                    phase_next     = PH_RX_LO;
                    sda_next       = 1'b1;
                end
                else
                begin
                    phase_next = PH_SP_LO;
                    sda_next   = 1'b0;
                end
            end
            PH_SP_LO:
            begin
                phase_next = PH_SP_HI;
                scl_next   = 1'b1;
                sda_next   = 1'b0;
            end
            PH_SP_HI:
            begin
                phase_next = PH_IDLE;
                scl_next   = 1'b1;
                sda_next   = 1'b1;
                done_next  = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
                scl_next   = 1'b1;
                sda_next   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= 7'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dev_addr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            stage_reg     <= ST_ADDR_W;
            bit_count_reg <= 3'd0;
            shift_reg     <= 8'd0;
            op_reg        <= 2'd0;
            reg_addr_reg  <= 8'd0;
            data_reg      <= 8'd0;
            read_word_reg <= 16'd0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            stage_reg     <= stage_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            op_reg        <= op_next;
            reg_addr_reg  <= reg_addr_next;
            data_reg      <= data_next;
            read_word_reg <= read_word_next;
            nack_reg      <= nack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rsp_reg.scl_level   <= scl_next;
            rsp_reg.sda_level   <= sda_next;
            rsp_reg.busy_res    <= (phase_next != PH_IDLE);
            rsp_reg.done_res    <= done_next;
            rsp_reg.read_data   <= read_word_next;
            rsp_reg.ack_missing <= nack_next;
        end
    end

endmodule

>>> design/i2cram_checker.sv
// ----------------------------------------------------------------------------
// I2C register access master checker
// Port-level properties of the response stream and the ready signals, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_register_access_master_top_assert.svh"

module i2cram_checker
    import i2cram_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input i2cram_rsp_t rsp,
    input logic        cfg_ready
);

    `I2CRAM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp moved")
    `I2CRAM_ASSERT(a_done_idle, rsp_valid && rsp.done_res |-> !rsp.busy_res, "done while busy")
    `I2CRAM_ASSERT(a_idle_released, rsp_valid && !rsp.busy_res |-> rsp.scl_level, "scl held")
    `I2CRAM_ASSERT(a_ready_free, !rsp_valid |-> req_ready, "request refused with empty output")
    `I2CRAM_ASSERT_ALWAYS(a_cfg_free, cfg_ready, "configuration write refused")

endmodule

bind i2c_register_access_master_top i2cram_checker u_i2cram_checker (.*);

>>> dv/i2c_register_access_master_top_tb.sv
// ----------------------------------------------------------------------------
// I2C register access master testbench
// Drives half-bit bus ticks as requests: write, byte read and word read
// transactions with random SDA, random commands while busy and undefined ops.
// Each response is checked against a tick-accurate model of the sequencer.
// The device address is rewritten between bursts, sometimes mid-transaction.
// ----------------------------------------------------------------------------
module i2c_register_access_master_top_tb;
    import i2cram_pkg::*;

    localparam int LEN_WRITE = 59;
    localparam int LEN_READ_BYTE = 81;
    localparam int LEN_READ_WORD = 99;
    localparam int RANDOM_TICKS = 500;
    localparam int LIMIT_CYCLES = 200000;

    typedef enum logic [3:0] {
        BUS_IDLE, BUS_START, BUS_START_HOLD, BUS_TX_LO, BUS_TX_HI,
        BUS_TACK_LO, BUS_TACK_HI, BUS_RX_LO, BUS_RX_HI, BUS_MACK_LO,
        BUS_MACK_HI, BUS_RS_LO, BUS_RS_HI, BUS_SP_LO, BUS_SP_HI
    } bus_phase_t;

    typedef enum logic [2:0] {
        BYTE_ADDR_W, BYTE_REG, BYTE_DATA, BYTE_ADDR_R, BYTE_READ1, BYTE_READ2
    } byte_slot_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    i2cram_req_t req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    i2cram_rsp_t rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;

    i2c_register_access_master_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // sequencer model state
    bus_phase_t m_phase = BUS_IDLE;
    byte_slot_t m_byte = BYTE_ADDR_W;
    logic [3:0]  m_bits = '0;
    logic [7:0]  m_shift = '0;
    logic [1:0]  m_op = '0;
    logic [7:0]  m_reg = '0;
    logic [7:0]  m_data = '0;
    logic [15:0] m_word = '0;
    logic        m_nack = 1'b0;
    logic        m_scl = 1'b1;
    logic        m_sda = 1'b1;
    logic [6:0]  m_dev_addr = '0;

    i2cram_req_t tick_plan[$];
    i2cram_req_t tick_queue[$];
    i2cram_rsp_t expected_ticks[$];

    int  queued_count = 0;
    int  sent_count = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_cycle = 0;
    int  stall_mode = 0;
    logic req_taken = 1'b0;
    logic cfg_taken = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void drive_bus(input bus_phase_t ph, input logic scl, input logic sda);
        m_phase = ph;
        m_scl = scl;
        m_sda = sda;
    endfunction

    function automatic void load_tx_byte();
        logic [7:0] v;
        case (m_byte)
            BYTE_ADDR_W: v = {m_dev_addr, 1'b0};
            BYTE_REG:    v = m_reg;
            BYTE_DATA:   v = m_data;
            default:     v = {m_dev_addr, 1'b1};
        endcase
        m_shift = v;
        m_bits = '0;
        drive_bus(BUS_TX_LO, 1'b0, v[7]);
    endfunction

    function automatic void load_rx_byte();
        m_shift = '0;
        m_bits = '0;
        drive_bus(BUS_RX_LO, 1'b0, 1'b1);
    endfunction

    function automatic i2cram_rsp_t advance_bus_tick(input i2cram_req_t t);
        i2cram_rsp_t r;
        logic done;
        logic more;
        done = 1'b0;
        case (m_phase)
            BUS_IDLE:
            begin
                if (t.cmd_valid && t.op != OP_UNDEFINED)
                begin
                    m_op = t.op;
                    m_reg = t.reg_addr;
                    m_data = t.write_data;
                    m_nack = 1'b0;
                    m_byte = BYTE_ADDR_W;
                    drive_bus(BUS_START, 1'b1, 1'b0);
                end
                else
                begin
                    drive_bus(BUS_IDLE, 1'b1, 1'b1);
                end
            end
            BUS_START:      drive_bus(BUS_START_HOLD, 1'b0, 1'b0);
            BUS_START_HOLD: load_tx_byte();
            BUS_TX_LO:      drive_bus(BUS_TX_HI, 1'b1, m_sda);
            BUS_TX_HI:
            begin
                if (m_bits >= 4'd7)
                begin
                    drive_bus(BUS_TACK_LO, 1'b0, 1'b1);
                end
                else
                begin
                    m_bits = m_bits + 4'd1;
                    m_shift = m_shift << 1;
                    drive_bus(BUS_TX_LO, 1'b0, m_shift[7]);
                end
            end
            BUS_TACK_LO:    drive_bus(BUS_TACK_HI, 1'b1, 1'b1);
            BUS_TACK_HI:
            begin
                if (t.sda_in)
                    m_nack = 1'b1;
                if (m_byte == BYTE_ADDR_W)
                begin
                    m_byte = BYTE_REG;
                    load_tx_byte();
                end
                else if (m_byte == BYTE_REG)
                begin
                    if (m_op == OP_WRITE)
                    begin
                        m_byte = BYTE_DATA;
                        load_tx_byte();
                    end
                    else
                    begin
                        m_byte = BYTE_ADDR_R;
                        drive_bus(BUS_RS_LO, 1'b0, 1'b1);
                    end
                end
                else if (m_byte == BYTE_ADDR_R)
                begin
                    m_byte = BYTE_READ1;
                    load_rx_byte();
                end
                else
                begin
                    drive_bus(BUS_SP_LO, 1'b0, 1'b0);
                end
            end
            BUS_RS_LO:      drive_bus(BUS_RS_HI, 1'b1, 1'b1);
            BUS_RS_HI:      drive_bus(BUS_START, 1'b1, 1'b0);
            BUS_RX_LO:      drive_bus(BUS_RX_HI, 1'b1, 1'b1);
            BUS_RX_HI:
            begin
                m_shift = {m_shift[6:0], t.sda_in};
                if (m_bits >= 4'd7)
                begin
                    more = (m_byte == BYTE_READ1) && (m_op == OP_READ_WORD);
                    if (more)
                        m_word = {m_shift, 8'h00};
                    else if (m_byte == BYTE_READ1)
                        m_word = {8'h00, m_shift};
                    else
                        m_word[7:0] = m_shift;
                    drive_bus(BUS_MACK_LO, 1'b0, !more);
                end
                else
                begin
                    m_bits = m_bits + 4'd1;
                    drive_bus(BUS_RX_LO, 1'b0, 1'b1);
                end
            end
            BUS_MACK_LO:    drive_bus(BUS_MACK_HI, 1'b1, m_sda);
            BUS_MACK_HI:
            begin
                if (!m_sda && m_byte == BYTE_READ1)
                begin
                    m_byte = BYTE_READ2;
                    load_rx_byte();
                end
                else
                begin
                    drive_bus(BUS_SP_LO, 1'b0, 1'b0);
                end
            end
            BUS_SP_LO:      drive_bus(BUS_SP_HI, 1'b1, 1'b0);
            BUS_SP_HI:
            begin
                drive_bus(BUS_IDLE, 1'b1, 1'b1);
                done = 1'b1;
            end
            default:        drive_bus(BUS_IDLE, 1'b1, 1'b1);
        endcase
        r.scl_level = m_scl;
        r.sda_level = m_sda;
        r.busy_res = (m_phase != BUS_IDLE);
        r.done_res = done;
        r.read_data = m_word;
        r.ack_missing = m_nack;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // request driver: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && !req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (tick_queue.size() != 0)
            begin
                req <= tick_queue.pop_front();
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response stalls: always ready, random, or a fixed duty pattern
    always @(negedge clk)
    begin
        stall_cycle++;
        if (stall_cycle % 97 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 2) != 0);
            default: rsp_ready <= ((stall_cycle % 7) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        req_taken = 1'b0;
        cfg_taken = 1'b0;
        if (rst_n)
        begin
            cfg_taken = cfg_valid && cfg_ready;
            if (cfg_taken)
                m_dev_addr = cfg_data;
            req_taken = req_valid && req_ready;
            if (req_taken)
            begin
                expected_ticks.push_back(advance_bus_tick(req));
                sent_count++;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_ticks.size() == 0)
                begin
                    $error("response with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    i2cram_rsp_t want;
                    want = expected_ticks.pop_front();
                    check_field("scl_level", 16'(want.scl_level), 16'(rsp.scl_level));
                    check_field("sda_level", 16'(want.sda_level), 16'(rsp.sda_level));
                    check_field("busy_res", 16'(want.busy_res), 16'(rsp.busy_res));
                    check_field("done_res", 16'(want.done_res), 16'(rsp.done_res));
                    check_field("read_data", want.read_data, rsp.read_data);
                    check_field("ack_missing", 16'(want.ack_missing), 16'(rsp.ack_missing));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic pick_sda(input int mode);
        case (mode)
            0:       return 1'($urandom_range(0, 1));
            1:       return 1'b0;
            2:       return 1'b1;
            default: return ($urandom_range(0, 7) == 0);
        endcase
    endfunction

    task automatic plan_transaction(input logic [1:0] op, input logic [7:0] reg_byte,
                                    input logic [7:0] data_byte, input int sda_mode);
        i2cram_req_t t;
        int length;
        int total;
        length = (op == OP_WRITE) ? LEN_WRITE :
                 (op == OP_READ_BYTE) ? LEN_READ_BYTE : LEN_READ_WORD;
        total = length + $urandom_range(0, 4);
        t.cmd_valid = 1'b1;
        t.op = op;
        t.reg_addr = reg_byte;
        t.write_data = data_byte;
        t.sda_in = pick_sda(sda_mode);
        tick_plan.push_back(t);
        for (int i = 1; i < total; i++)
        begin
            t.reg_addr = 8'($urandom);
            t.write_data = 8'($urandom);
            t.sda_in = pick_sda(sda_mode);
            if (i < length)
            begin
                t.cmd_valid = ($urandom_range(0, 5) == 0);
                t.op = 2'($urandom_range(0, 3));
            end
            else
            begin
                t.cmd_valid = 1'($urandom_range(0, 1));
                t.op = t.cmd_valid ? OP_UNDEFINED : 2'($urandom_range(0, 3));
            end
            tick_plan.push_back(t);
        end
    endtask

    task automatic release_ticks(input int n);
        repeat (n)
        begin
            tick_queue.push_back(tick_plan.pop_front());
            queued_count++;
        end
    endtask

    task automatic wait_quiet();
        do @(negedge clk);
        while (sent_count != queued_count || expected_ticks.size() != 0);
    endtask

    task automatic write_device_address(input logic [6:0] a);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= a;
        do @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int released;
        int cut;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_device_address(7'h00);
        plan_transaction(OP_WRITE, 8'h00, 8'h00, 1);
        plan_transaction(OP_WRITE, 8'hFF, 8'hFF, 2);
        plan_transaction(OP_UNDEFINED, 8'h5A, 8'hA5, 0);
        release_ticks(tick_plan.size());
        wait_quiet();

        write_device_address(7'h7F);
        plan_transaction(OP_READ_BYTE, 8'hFF, 8'h00, 2);
        plan_transaction(OP_READ_WORD, 8'h00, 8'hFF, 1);
        plan_transaction(OP_READ_BYTE, 8'hA5, 8'h3C, 0);
        release_ticks(tick_plan.size() - LEN_READ_BYTE + 30);
        wait_quiet();

        // address change lands during the register byte, before the read address
        write_device_address(7'h55);
        release_ticks(tick_plan.size());
        wait_quiet();

        released = 0;
        while (released < RANDOM_TICKS)
        begin
            repeat ($urandom_range(1, 3))
                plan_transaction(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom),
                                 $urandom_range(0, 3));
            cut = tick_plan.size();
            if ($urandom_range(0, 2) == 0)
                cut = cut - $urandom_range(1, 40);
            release_ticks(cut);
            released += cut;
            wait_quiet();
            case ($urandom_range(0, 3))
                0:       write_device_address(7'h00);
                1:       write_device_address(7'h7F);
                default: write_device_address(7'($urandom));
            endcase
        end
        release_ticks(tick_plan.size());
        wait_quiet();

        repeat (8) @(negedge clk);
        if (fail_count == 0 && expected_ticks.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
